/* rtl/core/hsv2rgb_pkg.sv */
`timescale 1ns / 1ps

package hsv2rgb_pkg;

   localparam int IN_W  = 12;   // hue, saturation, brightness
   localparam int OUT_W = 8;    // one color channel
   localparam int H6_W  = 15;   // 6 * hue
   localparam int Q_W   = 12;   // quotient of a divide by full scale, at most 4095

   // Divide by 255 through a reciprocal: exact for any dividend below 2**DIV_W.
   localparam int DIV_W    = 20;
   localparam int RECIP_W  = 21;
   localparam int RECIP_SH = 28;
   localparam logic [RECIP_W-1:0] RECIP_255 = 21'd1052689;   // ceil(2**28 / 255)

   localparam logic [OUT_W-1:0] CH_MAX = 8'd255;

   // Hue sectors: first channel at max, second one ramps.
   typedef enum logic [2:0] {
      SEC_RED_GRN = 3'd0,
      SEC_GRN_RED = 3'd1,
      SEC_GRN_BLU = 3'd2,
      SEC_BLU_GRN = 3'd3,
      SEC_BLU_RED = 3'd4,
      SEC_RED_BLU = 3'd5
   } sector_type;

   typedef struct packed {
      logic             valid;
      logic             gray;     // saturation zero
      logic             sec_ok;   // sector in 0..5
      sector_type       sector;
      logic [OUT_W-1:0] top;      // max channel, saturated
   } ctl_type;

endpackage

/* rtl/core/hsv2rgb_front.sv */
`timescale 1ns / 1ps

module hsv2rgb_front #(
   parameter int FRAC_BITS = 4,
   localparam int VSH_W = 16 - FRAC_BITS,
   localparam int HW    = 9 + FRAC_BITS,
   localparam int FS_W  = 8 + FRAC_BITS,
   localparam int CW    = (FS_W > 12) ? FS_W : 12,
   localparam int RST_W = 12 + CW
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [hsv2rgb_pkg::IN_W-1:0]  hue,
   input  logic [hsv2rgb_pkg::IN_W-1:0]  sat,
   input  logic [hsv2rgb_pkg::IN_W-1:0]  val,
   output hsv2rgb_pkg::ctl_type          ctl_ff,
   output logic [VSH_W-1:0]              vs_hi_ff,
   output logic [HW-1:0]                 ramp_ff,
   output logic [RST_W-1:0]              rest_ff
);
   import hsv2rgb_pkg::*;

   localparam int SPAN_SH = 8 + FRAC_BITS;
   localparam int TW      = (HW + 1 > H6_W) ? HW + 1 : H6_W;
   localparam logic [CW-1:0] FULL_SCALE = CW'(255) << FRAC_BITS;

   logic [CW-1:0]        s_w, v_w, s_c, v_c, s_rem;
   logic [2*IN_W-1:0]    vs;
   logic [H6_W-1:0]      h6, sec_raw, base;
   logic [TW-1:0]        t_w, hs_w;
   logic [IN_W-1:0]      v_top;
   ctl_type              ctl_in;
   logic [VSH_W-1:0]     vs_hi_in;
   logic [HW-1:0]        ramp_in;
   logic [RST_W-1:0]     rest_in;

   always_comb begin
      // clamp to full scale
      s_w   = CW'(sat);
      v_w   = CW'(val);
      s_c   = (s_w > FULL_SCALE) ? FULL_SCALE : s_w;
      v_c   = (v_w > FULL_SCALE) ? FULL_SCALE : v_w;
      s_rem = FULL_SCALE - s_c;

      vs       = (2*IN_W)'(v_c[IN_W-1:0]) * (2*IN_W)'(s_c[IN_W-1:0]);
      vs_hi_in = vs[2*IN_W-1:SPAN_SH];
      rest_in  = RST_W'(v_c[IN_W-1:0]) * RST_W'(s_rem);

      // sector and triangle ramp over the sector pair
      h6      = H6_W'(hue) * H6_W'(6);
      sec_raw = h6 >> SPAN_SH;
      base    = (sec_raw & ~H6_W'(1)) << SPAN_SH;
      t_w     = TW'(h6 - base);
      hs_w    = TW'(1) << SPAN_SH;
      ramp_in = (t_w < hs_w) ? HW'(t_w) : HW'((hs_w << 1) - t_w);

      v_top          = v_c[IN_W-1:0] >> FRAC_BITS;
      ctl_in.valid   = in_valid;
      ctl_in.gray    = (s_c == '0);
      ctl_in.sec_ok  = (sec_raw <= H6_W'(SEC_RED_BLU));
      ctl_in.sector  = ctl_in.sec_ok ? sector_type'(sec_raw[2:0]) : SEC_RED_GRN;
      ctl_in.top     = (v_top > IN_W'(CH_MAX)) ? CH_MAX : v_top[OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      vs_hi_ff <= vs_hi_in;
      ramp_ff  <= ramp_in;
      rest_ff  <= rest_in;
   end

endmodule

/* rtl/core/hsv2rgb_scale.sv */
`timescale 1ns / 1ps

module hsv2rgb_scale #(
   parameter int FRAC_BITS = 4,
   localparam int VSH_W = 16 - FRAC_BITS,
   localparam int HW    = 9 + FRAC_BITS,
   localparam int FS_W  = 8 + FRAC_BITS,
   localparam int CW    = (FS_W > 12) ? FS_W : 12,
   localparam int RST_W = 12 + CW
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hsv2rgb_pkg::ctl_type          ctl_i,
   input  logic [VSH_W-1:0]              vs_hi,
   input  logic [HW-1:0]                 ramp,
   input  logic [RST_W-1:0]              rest,
   output hsv2rgb_pkg::ctl_type          ctl_ff,
   output logic [hsv2rgb_pkg::Q_W-1:0]   qx_ff,
   output logic [hsv2rgb_pkg::Q_W-1:0]   qm_ff
);
   import hsv2rgb_pkg::*;

   localparam int XW    = VSH_W + HW;
   localparam int SUM_W = ((XW > RST_W) ? XW : RST_W) + 1;
   localparam int PW    = DIV_W + RECIP_W;

   // stage 2: ramp product
   ctl_type           ctl2_ff;
   logic [XW-1:0]     x_ff, x_in;
   logic [RST_W-1:0]  rest2_ff;
   // stage 3: sum, drop fraction bits
   ctl_type           ctl3_ff;
   logic [SUM_W-1:0]  sum;
   logic [DIV_W-1:0]  nx_ff, nx_in, nm_ff, nm_in;
   // stage 4: divide by 255
   logic [PW-1:0]     px, pm;
   logic [Q_W-1:0]    qx_in, qm_in;

   always_comb begin
      x_in  = XW'(vs_hi) * XW'(ramp);
      sum   = SUM_W'(x_ff) + SUM_W'(rest2_ff);
      nx_in = sum[FRAC_BITS +: DIV_W];
      nm_in = rest2_ff[FRAC_BITS +: DIV_W];
      px    = PW'(nx_ff) * PW'(RECIP_255);
      pm    = PW'(nm_ff) * PW'(RECIP_255);
      qx_in = px[RECIP_SH +: Q_W];
      qm_in = pm[RECIP_SH +: Q_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl_ff  <= '0;
      end else begin
         ctl2_ff <= ctl_i;
         ctl3_ff <= ctl2_ff;
         ctl_ff  <= ctl3_ff;
      end
      x_ff     <= x_in;
      rest2_ff <= rest;
      nx_ff    <= nx_in;
      nm_ff    <= nm_in;
      qx_ff    <= qx_in;
      qm_ff    <= qm_in;
   end

endmodule

/* rtl/core/hsv_to_rgb_fixed_point_unit.sv */
`timescale 1ns / 1ps

// channel   ports                                         handshake
// --------  --------------------------------------------  -----------------------------
// request   req_hue, req_saturation, req_brightness       taken when start && !busy
// response  rsp_red, rsp_green, rsp_blue                  one-cycle strobe rsp_valid
//
// One item per clock; busy is always low since no stage ever waits.
// From the accepting edge to the result register the pipe runs through these steps in order:
// clamp and products, ramp multiply, sum, reciprocal divide by 255, channel select.
// Reset (synchronous, active high) clears the control words of the pipe and rsp_valid; data registers are not reset.
// The receiver cannot stall, so results leave on the fixed schedule.

module hsv_to_rgb_fixed_point_unit #(
   parameter int FRAC_BITS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [hsv2rgb_pkg::IN_W-1:0]  req_hue,
   input  logic [hsv2rgb_pkg::IN_W-1:0]  req_saturation,
   input  logic [hsv2rgb_pkg::IN_W-1:0]  req_brightness,
   output logic                          rsp_valid,
   output logic [hsv2rgb_pkg::OUT_W-1:0] rsp_red,
   output logic [hsv2rgb_pkg::OUT_W-1:0] rsp_green,
   output logic [hsv2rgb_pkg::OUT_W-1:0] rsp_blue
);
   import hsv2rgb_pkg::*;

   localparam int VSH_W = 16 - FRAC_BITS;
   localparam int HW    = 9 + FRAC_BITS;
   localparam int FS_W  = 8 + FRAC_BITS;
   localparam int CW    = (FS_W > 12) ? FS_W : 12;
   localparam int RST_W = 12 + CW;
   localparam logic [Q_W:0] ROUND_HALF = (Q_W + 1)'(1) << (FRAC_BITS - 1);

   ctl_type            ctl1, ctl4;
   logic [VSH_W-1:0]   vs_hi;
   logic [HW-1:0]      ramp;
   logic [RST_W-1:0]   rest;
   logic [Q_W-1:0]     qx, qm;

   logic [Q_W:0]       x_round;
   logic [Q_W-1:0]     m_shift;
   logic [OUT_W-1:0]   mid, lo;
   logic               valid_in;
   logic [OUT_W-1:0]   red_in, green_in, blue_in;

   // pipe never holds, so the request side is always open
   assign busy = 1'b0;

   hsv2rgb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start & ~busy),
      .hue      (req_hue),
      .sat      (req_saturation),
      .val      (req_brightness),
      .ctl_ff   (ctl1),
      .vs_hi_ff (vs_hi),
      .ramp_ff  (ramp),
      .rest_ff  (rest)
   );

   hsv2rgb_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
      .clock  (clock),
      .reset  (reset),
      .ctl_i  (ctl1),
      .vs_hi  (vs_hi),
      .ramp   (ramp),
      .rest   (rest),
      .ctl_ff (ctl4),
      .qx_ff  (qx),
      .qm_ff  (qm)
   );

   // stage 5: round, saturate, route by sector
   always_comb begin
      x_round = ((Q_W + 1)'(qx) + ROUND_HALF) >> FRAC_BITS;
      m_shift = qm >> FRAC_BITS;
      mid     = (x_round > (Q_W + 1)'(CH_MAX)) ? CH_MAX : x_round[OUT_W-1:0];
      lo      = (m_shift > Q_W'(CH_MAX)) ? CH_MAX : m_shift[OUT_W-1:0];

      valid_in = ctl4.valid;
      red_in   = '0;
      green_in = '0;
      blue_in  = '0;
      if (ctl4.gray) begin
         red_in   = ctl4.top;
         green_in = ctl4.top;
         blue_in  = ctl4.top;
      end else if (ctl4.sec_ok) begin
         unique case (ctl4.sector)
            SEC_RED_GRN: begin red_in = ctl4.top; green_in = mid;      blue_in = lo;       end
            SEC_GRN_RED: begin red_in = mid;      green_in = ctl4.top; blue_in = lo;       end
            SEC_GRN_BLU: begin red_in = lo;       green_in = ctl4.top; blue_in = mid;      end
            SEC_BLU_GRN: begin red_in = lo;       green_in = mid;      blue_in = ctl4.top; end
            SEC_BLU_RED: begin red_in = mid;      green_in = lo;       blue_in = ctl4.top; end
            SEC_RED_BLU: begin red_in = ctl4.top; green_in = lo;       blue_in = mid;      end
            default:     begin red_in = '0;       green_in = '0;       blue_in = '0;       end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= valid_in;
      end
      rsp_red   <= red_in;
      rsp_green <= green_in;
      rsp_blue  <= blue_in;
   end

endmodule
